@@ hw/rtl/iair_pkg.sv @@
// Shared constants and codes for the indexed word list block.
package iair_pkg;

  // Default sizing
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_WORD_WIDTH = 32;

  // Fixed port field widths
  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 7;
  localparam int WORD_IN_W  = 32;
  localparam int WORD_OUT_W = 32;
  localparam int ENTRIES_W  = 7;
  localparam int STATUS_W   = 2;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_OVERWRITE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ      = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LENGTH    = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ hw/rtl/indexed_array_insert_remove.sv @@
// Indexed word list: append, insert, remove, overwrite, read, length over one RAM.
//
//   channel  | ports                                             | handshake
//   ---------+---------------------------------------------------+--------------------------
//   request  | in_opcode, in_position, in_word_in                | start && !busy
//   result   | out_word_out, out_entries_used, out_status        | out_valid, one cycle
//
// Append, overwrite, length, insert at the end and errors finish in S_DECODE; read adds S_RDWAIT.
// Insert below the count walks S_SHUP from the last entry down to position, then S_FINAL writes
// the new word; remove walks S_SHDN from position + 1 up to the last entry. The
// single-port-write RAM moves one entry per cycle during the shift. Reset clears the count
// and control; RAM contents are never cleared.
// The receiver cannot stall: each result is shown for one cycle and busy drops with it.
module indexed_array_insert_remove
  import iair_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [POSITION_W-1:0] in_position,
  input  logic [WORD_IN_W-1:0]  in_word_in,
  output logic                  out_valid,
  output logic [WORD_OUT_W-1:0] out_word_out,
  output logic [ENTRIES_W-1:0]  out_entries_used,
  output logic [STATUS_W-1:0]   out_status
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SHUP   = 3'd3;
  localparam logic [2:0] S_SHDN   = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [OPCODE_W-1:0]   op_r;
  logic [POSITION_W-1:0] pos_r;
  logic [WORD_WIDTH-1:0] word_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_OUT_W-1:0] out_word_r, out_word_nxt;
  logic [ENTRIES_W-1:0]  out_entries_r;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // Entry RAM
  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0] mem_wdata;

  // Index checks
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            pos_gt_cnt, pos_ge_cnt, list_full, pos_is_last;
  logic [AW-1:0]   pos_addr, cnt_addr, last_addr;

  assign pos_ext     = CMPW'(pos_r);
  assign cnt_ext     = CMPW'(count_r);
  assign pos_gt_cnt  = pos_ext > cnt_ext;
  assign pos_ge_cnt  = pos_ext >= cnt_ext;
  assign list_full   = count_r == CW'(CAPACITY);
  assign pos_addr    = AW'(pos_r);
  assign cnt_addr    = AW'(count_r);
  assign last_addr   = AW'(count_r - CW'(1));
  assign pos_is_last = pos_addr == last_addr;

  // Sequencer and datapath control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_addr;
    mem_wdata      = word_r;
    mem_raddr      = ptr_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = '0;
    out_status_nxt = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        priority case (op_r)
          OP_APPEND: begin
            if (list_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_addr;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_INSERT: begin
            if (pos_gt_cnt) begin
              out_status_nxt = ST_RANGE;
            end else if (list_full) begin
              out_status_nxt = ST_FULL;
            end else if (pos_ext == cnt_ext) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              // open a gap: walk down from the last entry
              mem_raddr     = last_addr;
              ptr_nxt       = last_addr;
              out_valid_nxt = 1'b0;
              state_nxt     = S_SHUP;
            end
          end
          OP_REMOVE: begin
            if (pos_ge_cnt) begin
              out_status_nxt = ST_RANGE;
            end else if (pos_is_last) begin
              count_nxt = count_r - CW'(1);
            end else begin
              // close the gap: walk up from the entry after position
              mem_raddr     = pos_addr + AW'(1);
              ptr_nxt       = pos_addr + AW'(1);
              out_valid_nxt = 1'b0;
              state_nxt     = S_SHDN;
            end
          end
          OP_OVERWRITE: begin
            if (pos_ge_cnt) out_status_nxt = ST_RANGE;
            else mem_we = 1'b1;
          end
          OP_READ: begin
            if (pos_ge_cnt) begin
              out_status_nxt = ST_RANGE;
            end else begin
              mem_raddr     = pos_addr;
              out_valid_nxt = 1'b0;
              state_nxt     = S_RDWAIT;
            end
          end
          default: begin
            // length and unused codes just report the count
          end
        endcase
      end
      S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = WORD_OUT_W'(rdata_r);
        state_nxt     = S_IDLE;
      end
      S_SHUP: begin
        // entry ptr moves to ptr + 1
        mem_we    = 1'b1;
        mem_waddr = ptr_r + AW'(1);
        mem_wdata = rdata_r;
        if (ptr_r == pos_addr) begin
          state_nxt = S_FINAL;
        end else begin
          mem_raddr = ptr_r - AW'(1);
          ptr_nxt   = ptr_r - AW'(1);
        end
      end
      S_FINAL: begin
        mem_we        = 1'b1;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SHDN: begin
        // entry ptr moves to ptr - 1
        mem_we    = 1'b1;
        mem_waddr = ptr_r - AW'(1);
        mem_wdata = rdata_r;
        if (ptr_r == last_addr) begin
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          mem_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (state_r == S_IDLE && start) begin
      op_r   <= in_opcode;
      pos_r  <= in_position;
      word_r <= WORD_WIDTH'(in_word_in);
    end
    if (out_valid_nxt) begin
      out_word_r    <= out_word_nxt;
      out_entries_r <= ENTRIES_W'(count_nxt);
      out_status_r  <= out_status_nxt;
    end
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_word_out     = out_word_r;
  assign out_entries_used = out_entries_r;
  assign out_status       = out_status_r;

endmodule

@@ hw/rtl/iair_checker.sv @@
// Port-level checker for the indexed word list, bound to the top level.
module iair_checker
  import iair_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [WORD_OUT_W-1:0] out_word_out,
  input logic [STATUS_W-1:0]   out_status
);

  // a result beat is a single-cycle pulse
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // an accepted request keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  // the block is free again whenever it shows a result
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // a failed request never returns data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_word_out == '0)
    else $error("nonzero word on an error result");

endmodule

bind indexed_array_insert_remove iair_checker u_iair_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_word_out (out_word_out),
  .out_status   (out_status)
);
